>>> rtl/tsse_pkg.sv
// ----------------------------------------------------------------------------
// tsse_pkg
// Shared types, constants and arithmetic helpers of the twisted sphere
// surface evaluator.
// ----------------------------------------------------------------------------
package tsse_pkg;

  localparam int CW = 36;

  localparam logic signed [CW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [CW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [CW-1:0] GAIN_Q30    = 36'sd652032874;

  typedef enum logic [2:0] {
    KIND_POS    = 3'd0,
    KIND_DU     = 3'd1,
    KIND_DV     = 3'd2,
    KIND_NORMAL = 3'd3,
    KIND_DUU    = 3'd4,
    KIND_DUV    = 3'd5,
    KIND_DVV    = 3'd6
  } vec_kind_e;

  localparam logic [1:0] REG_A_SCALE = 2'd0;
  localparam logic [1:0] REG_B_TWIST = 2'd1;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 neg;
  } lane_t;

  typedef struct packed {
    lane_t       u_lane;
    lane_t       v_lane;
    logic [14:0] u;
  } cell_data_t;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
  } vec_t;

  function automatic logic signed [CW-1:0] atan_q30(input int i);
    logic signed [CW-1:0] r;
    unique case (i)
      0:  r = 36'sd843314857;
      1:  r = 36'sd497837829;
      2:  r = 36'sd263043837;
      3:  r = 36'sd133525159;
      4:  r = 36'sd67021687;
      5:  r = 36'sd33543516;
      6:  r = 36'sd16775851;
      7:  r = 36'sd8388437;
      8:  r = 36'sd4194283;
      9:  r = 36'sd2097149;
      10: r = 36'sd1048576;
      11: r = 36'sd524288;
      12: r = 36'sd262144;
      13: r = 36'sd131072;
      14: r = 36'sd65536;
      15: r = 36'sd32768;
      16: r = 36'sd16384;
      17: r = 36'sd8192;
      18: r = 36'sd4096;
      19: r = 36'sd2048;
      20: r = 36'sd1024;
      21: r = 36'sd512;
      22: r = 36'sd256;
      23: r = 36'sd128;
      default: r = '0;
    endcase
    return r;
  endfunction

  // round a q30 angle to f fraction bits, half up
  function automatic logic signed [CW-1:0] angle_const(input logic signed [CW-1:0] q,
                                                       input int f);
    logic signed [CW-1:0] one;
    one = 36'sd1;
    return (q + (one <<< (30 - f - 1))) >>> (30 - f);
  endfunction

  function automatic lane_t lane_init(input logic signed [CW-1:0] theta);
    lane_t l;
    l.x   = GAIN_Q30;
    l.y   = '0;
    l.z   = theta;
    l.neg = 1'b0;
    if (theta > HALF_PI_Q30) begin
      l.z   = theta - PI_Q30;
      l.neg = 1'b1;
    end else if (theta < -HALF_PI_Q30) begin
      l.z   = theta + PI_Q30;
      l.neg = 1'b1;
    end
    return l;
  endfunction

  // q12 product rounded half up
  function automatic logic signed [17:0] mulq(input logic signed [17:0] a,
                                              input logic signed [17:0] b);
    logic signed [35:0] p;
    p = a * b + 36'sd2048;
    return p[29:12];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
    logic signed [23:0] r;
    if (v > 26'sd8388607) r = 24'sh7fffff;
    else if (v < -26'sd8388608) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

endpackage

>>> rtl/tsse_if.sv
// ----------------------------------------------------------------------------
// tsse_in_if / tsse_out_if
// Valid/ready channels carrying the angle word and the result vector word.
// ----------------------------------------------------------------------------
interface tsse_in_if;
  logic               valid;
  logic               ready;
  logic        [14:0] u_angle;
  logic signed [14:0] v_angle;
  modport source (output valid, u_angle, v_angle, input ready);
  modport sink (input valid, u_angle, v_angle, output ready);
endinterface

interface tsse_out_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  vec_kind;
  logic signed [23:0] vec_x;
  logic signed [23:0] vec_y;
  logic signed [23:0] vec_z;
  logic               last_vec;
  modport source (output valid, vec_kind, vec_x, vec_y, vec_z, last_vec, input ready);
  modport sink (input valid, vec_kind, vec_x, vec_y, vec_z, last_vec, output ready);
endinterface

>>> rtl/twisted_sphere_surface_eval_core.sv
// an accepted angle word passes the rotation chain, the trig and product registers
// and the serializer register; the serializer sends seven vector words per angle word
// the rotation chain and product stages take a new word every cycle while the
// serializer is free; reset clears all valid bits and loads a and b with 1.0
// ----------------------------------------------------------------------------
// twisted_sphere_surface_eval_core
// Evaluates the twisted sphere surface and its derivatives for an angle pair.
// ----------------------------------------------------------------------------
module twisted_sphere_surface_eval_core import tsse_pkg::*; #(
  parameter int TRIG_STEPS      = 16,
  parameter int ANGLE_FRAC_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  tsse_in_if.sink     in_if,
  tsse_out_if.source  out_if
);

  localparam logic signed [CW-1:0] PI_F    = angle_const(PI_Q30, ANGLE_FRAC_BITS);
  localparam logic signed [CW-1:0] TWOPI_F = angle_const(PI_Q30 <<< 1, ANGLE_FRAC_BITS);
  localparam int SHIFT = 30 - ANGLE_FRAC_BITS;

  logic signed [15:0] a_q, b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= 16'sd4096;
      b_q <= 16'sd4096;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_A_SCALE: a_q <= cfg_data_i;
        REG_B_TWIST: b_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamp and fold angles
  logic signed [CW-1:0] u_w, v_w, tu, tv;
  cell_data_t           front;
  logic                 en;

  always_comb begin
    u_w = {21'b0, in_if.u_angle};
    v_w = {{21{in_if.v_angle[14]}}, in_if.v_angle};
    if (u_w > TWOPI_F) u_w = TWOPI_F;
    if (v_w > PI_F) v_w = PI_F;
    if (v_w < -PI_F) v_w = -PI_F;
    tu = u_w <<< SHIFT;
    if (tu > PI_Q30) tu = tu - (PI_Q30 <<< 1);
    tv = v_w <<< SHIFT;
    front.u_lane = lane_init(tu);
    front.v_lane = lane_init(tv);
    front.u      = u_w[14:0];
  end

  logic       c_valid [TRIG_STEPS+1];
  cell_data_t c_data  [TRIG_STEPS+1];

  assign c_valid[0] = in_if.valid;
  assign c_data[0]  = front;
  assign in_if.ready = en;

  for (genvar g = 0; g < TRIG_STEPS; g++) begin : g_cell
    tsse_cordic_cell #(.STEP(g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (c_valid[g]),
      .data_i  (c_data[g]),
      .valid_o (c_valid[g+1]),
      .data_o  (c_data[g+1])
    );
  end

  tsse_vec_unit #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_vec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c_valid[TRIG_STEPS]),
    .data_i  (c_data[TRIG_STEPS]),
    .a_i     (a_q),
    .b_i     (b_q),
    .en_o    (en),
    .out_if  (out_if)
  );

endmodule

>>> rtl/tsse_cordic_cell.sv
// ----------------------------------------------------------------------------
// tsse_cordic_cell
// One registered rotation step for the u and v lanes.
// ----------------------------------------------------------------------------
module tsse_cordic_cell import tsse_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  cell_data_t data_i,
  output logic       valid_o,
  output cell_data_t data_o
);

  localparam logic signed [CW-1:0] ATAN = atan_q30(STEP);

  logic       valid_q;
  cell_data_t data_d, data_q;

  function automatic lane_t rotate(input lane_t l);
    lane_t r;
    r = l;
    if (l.z >= 0) begin
      r.x = l.x - (l.y >>> STEP);
      r.y = l.y + (l.x >>> STEP);
      r.z = l.z - ATAN;
    end else begin
      r.x = l.x + (l.y >>> STEP);
      r.y = l.y - (l.x >>> STEP);
      r.z = l.z + ATAN;
    end
    return r;
  endfunction

  always_comb begin
    data_d        = data_i;
    data_d.u_lane = rotate(data_i.u_lane);
    data_d.v_lane = rotate(data_i.v_lane);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> rtl/tsse_vec_unit.sv
// ----------------------------------------------------------------------------
// tsse_vec_unit
// Rounds sin/cos, forms the products, and streams the seven vectors.
// ----------------------------------------------------------------------------
module tsse_vec_unit import tsse_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  cell_data_t         data_i,
  input  logic signed [15:0] a_i,
  input  logic signed [15:0] b_i,
  output logic               en_o,
  tsse_out_if.source         out_if
);

  localparam logic signed [32:0] BU_RND = 33'sd1 <<< (ANGLE_FRAC_BITS - 1);

  logic en;

  // trig stage
  logic               t_valid_q;
  logic signed [17:0] su_q, cu_q, sv_q, cv_q;
  logic        [14:0] tu_q;

  function automatic logic signed [17:0] round_q12(input logic signed [CW-1:0] v,
                                                   input logic neg);
    logic signed [CW-1:0] s;
    s = (neg ? -v : v) + 36'sd131072;
    return s[35:18];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_valid_q <= 1'b0;
    end else if (en) begin
      t_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cu_q <= round_q12(data_i.u_lane.x, data_i.u_lane.neg);
      su_q <= round_q12(data_i.u_lane.y, data_i.u_lane.neg);
      cv_q <= round_q12(data_i.v_lane.x, data_i.v_lane.neg);
      sv_q <= round_q12(data_i.v_lane.y, data_i.v_lane.neg);
      tu_q <= data_i.u;
    end
  end

  // product stage
  logic               p_valid_q;
  logic signed [17:0] acu_q, asu_q, nacu_q, nasu_q, asv_q, nasv_q, acv_q, cv2_q;
  logic signed [17:0] nbsu_q, bcu_q, pcv_q, psv_q;
  logic signed [23:0] bu_q, b_q;
  logic signed [17:0] a18, na18, b18, nb18;
  logic signed [32:0] bu_full;

  assign a18     = {{2{a_i[15]}}, a_i};
  assign na18    = -a18;
  assign b18     = {{2{b_i[15]}}, b_i};
  assign nb18    = -b18;
  assign bu_full = (33'(b_i) * 33'($signed({1'b0, tu_q})) + BU_RND) >>> ANGLE_FRAC_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (en) begin
      p_valid_q <= t_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      acu_q  <= mulq(a18, cu_q);
      asu_q  <= mulq(a18, su_q);
      nacu_q <= mulq(na18, cu_q);
      nasu_q <= mulq(na18, su_q);
      asv_q  <= mulq(a18, sv_q);
      nasv_q <= mulq(na18, sv_q);
      acv_q  <= mulq(a18, cv_q);
      cv2_q  <= mulq(cv_q, cv_q);
      nbsu_q <= mulq(nb18, su_q);
      bcu_q  <= mulq(b18, cu_q);
      pcv_q  <= cv_q;
      psv_q  <= sv_q;
      bu_q   <= bu_full[23:0];
      b_q    <= {{8{b_i[15]}}, b_i};
    end
  end

  // vector forming
  vec_t vec_d [7];

  function automatic logic signed [25:0] ext(input logic signed [17:0] v);
    return {{8{v[17]}}, v};
  endfunction

  function automatic vec_t mk(input logic signed [25:0] x,
                              input logic signed [25:0] y,
                              input logic signed [25:0] z);
    vec_t r;
    r.x = sat24(x);
    r.y = sat24(y);
    r.z = sat24(z);
    return r;
  endfunction

  always_comb begin
    vec_d[KIND_POS] = mk(ext(mulq(acu_q, pcv_q)),
                         ext(asv_q) + {{2{bu_q[23]}}, bu_q},
                         ext(mulq(asu_q, pcv_q)));
    vec_d[KIND_DU] = mk(ext(nasu_q), {{2{b_q[23]}}, b_q}, ext(acu_q));
    vec_d[KIND_DV] = mk(ext(mulq(nacu_q, psv_q)), ext(acv_q),
                        ext(mulq(nasu_q, psv_q)));
    vec_d[KIND_NORMAL] = mk(ext(mulq(nbsu_q, psv_q)) - ext(mulq(acu_q, cv2_q)),
                            ext(mulq(nasv_q, pcv_q)),
                            ext(mulq(bcu_q, psv_q)) - ext(mulq(asu_q, cv2_q)));
    vec_d[KIND_DUU] = mk(ext(nacu_q), '0, ext(nasu_q));
    vec_d[KIND_DUV] = mk(ext(asu_q), '0, ext(nacu_q));
    vec_d[KIND_DVV] = mk(ext(mulq(nacu_q, pcv_q)), ext(nasv_q),
                         ext(mulq(nasu_q, pcv_q)));
  end

  // output serializer
  logic       s_valid_q, s_valid_d;
  logic [2:0] idx_q, idx_d;
  vec_t       vec_q [7];
  logic       take, done;

  assign take = s_valid_q & out_if.ready;
  assign done = take & (idx_q == KIND_DVV);
  assign en   = !s_valid_q | done;
  assign en_o = en;

  always_comb begin
    s_valid_d = s_valid_q;
    idx_d     = idx_q;
    if (en) begin
      s_valid_d = p_valid_q;
      idx_d     = KIND_POS;
    end else if (take) begin
      idx_d = idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
      idx_q     <= KIND_POS;
    end else begin
      s_valid_q <= s_valid_d;
      idx_q     <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vec_q <= vec_d;
    end
  end

  assign out_if.valid    = s_valid_q;
  assign out_if.vec_kind = idx_q;
  assign out_if.vec_x    = vec_q[idx_q].x;
  assign out_if.vec_y    = vec_q[idx_q].y;
  assign out_if.vec_z    = vec_q[idx_q].z;
  assign out_if.last_vec = (idx_q == KIND_DVV);

endmodule

>>> sim/tb_twisted_sphere_surface_eval_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_twisted_sphere_surface_eval_core
// Drives angle words with random gaps, collects the seven vector words of each
// angle with random stalls, and compares them against a fixed-point model of
// the surface and its derivatives under several coefficient settings.
// ----------------------------------------------------------------------------
module tb_twisted_sphere_surface_eval_core;
  import tsse_pkg::*;

  localparam int TRIG_STEPS      = 16;
  localparam int ANGLE_FRAC_BITS = 12;
  localparam int LATENCY         = TRIG_STEPS + 12;

  typedef struct {
    logic [14:0]        u;
    logic signed [14:0] v;
  } angle_t;

  typedef struct {
    vec_kind_e          kind;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic               last;
  } surf_vec_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  tsse_in_if  in_if ();
  tsse_out_if out_if ();

  twisted_sphere_surface_eval_core #(
    .TRIG_STEPS     (TRIG_STEPS),
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_if     (in_if.sink),
    .out_if    (out_if.source)
  );

  angle_t    angle_q[$];
  surf_vec_t vec_q[$];
  longint    coef_a;
  longint    coef_b;
  int        errors;
  int        drive_gap;
  int        sink_gap;
  bit        hold_off;
  bit        in_acc;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint fshift(longint x, int s);
    return x >>> s;
  endfunction

  function automatic longint qmul(longint x, longint y);
    return fshift(x * y + 2048, 12);
  endfunction

  function automatic logic signed [23:0] clip24(longint x);
    if (x > 64'sd8388607) return 24'sh7fffff;
    if (x < -64'sd8388608) return 24'sh800000;
    return x[23:0];
  endfunction

  function automatic longint round_angle(longint q30);
    int d;
    d = 30 - ANGLE_FRAC_BITS;
    return fshift(q30 + (64'sd1 <<< (d - 1)), d);
  endfunction

  task automatic cordic_sincos(input longint theta, output longint s, output longint c);
    longint x, y, z, nx, ny, pi30, tbl[24];
    bit flip;
    tbl = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
            16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
            131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};
    pi30 = 64'sd3373259426;
    x = 652032874;
    y = 0;
    z = theta;
    flip = 0;
    if (z > pi30 / 2) begin
      z -= pi30;
      flip = 1;
    end else if (z < -(pi30 / 2)) begin
      z += pi30;
      flip = 1;
    end
    for (int i = 0; i < TRIG_STEPS && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - fshift(y, i);
        ny = y + fshift(x, i);
        z -= tbl[i];
      end else begin
        nx = x + fshift(y, i);
        ny = y - fshift(x, i);
        z += tbl[i];
      end
      x = nx;
      y = ny;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = fshift(x + (64'sd1 <<< 17), 18);
    s = fshift(y + (64'sd1 <<< 17), 18);
  endtask

  task automatic push_vec(vec_kind_e k, longint x, longint y, longint z);
    surf_vec_t e;
    e.kind = k;
    e.x = clip24(x);
    e.y = clip24(y);
    e.z = clip24(z);
    e.last = (k == KIND_DVV);
    vec_q.push_back(e);
  endtask

  task automatic predict_surface(angle_t w);
    longint pi30, pif, twopif, u, v, tu, su, cu, sv, cv, cv2, a, b, bu;
    pi30 = 64'sd3373259426;
    pif = round_angle(pi30);
    twopif = round_angle(2 * pi30);
    u = w.u;
    v = w.v;
    a = coef_a;
    b = coef_b;
    if (u > twopif) u = twopif;
    if (v > pif) v = pif;
    if (v < -pif) v = -pif;
    tu = u <<< (30 - ANGLE_FRAC_BITS);
    if (tu > pi30) tu -= 2 * pi30;
    cordic_sincos(tu, su, cu);
    cordic_sincos(v <<< (30 - ANGLE_FRAC_BITS), sv, cv);
    bu = fshift(b * u + (64'sd1 <<< (ANGLE_FRAC_BITS - 1)), ANGLE_FRAC_BITS);
    cv2 = qmul(cv, cv);
    push_vec(KIND_POS, qmul(qmul(a, cu), cv), qmul(a, sv) + bu, qmul(qmul(a, su), cv));
    push_vec(KIND_DU, qmul(-a, su), b, qmul(a, cu));
    push_vec(KIND_DV, qmul(qmul(-a, cu), sv), qmul(a, cv), qmul(qmul(-a, su), sv));
    push_vec(KIND_NORMAL, qmul(qmul(-b, su), sv) - qmul(qmul(a, cu), cv2),
             qmul(qmul(-a, sv), cv), qmul(qmul(b, cu), sv) - qmul(qmul(a, su), cv2));
    push_vec(KIND_DUU, qmul(-a, cu), 0, qmul(-a, su));
    push_vec(KIND_DUV, qmul(a, su), 0, qmul(-a, cu));
    push_vec(KIND_DVV, qmul(qmul(-a, cu), cv), qmul(-a, sv), qmul(qmul(-a, su), cv));
  endtask

  // driver
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid   <= 1'b0;
      in_if.u_angle <= '0;
      in_if.v_angle <= '0;
      drive_gap     <= 0;
    end else if (in_if.valid && !in_acc) begin
    end else if (drive_gap > 0 || hold_off) begin
      in_if.valid <= 1'b0;
      if (drive_gap > 0) drive_gap <= drive_gap - 1;
    end else if (angle_q.size() > 0) begin
      in_if.valid   <= 1'b1;
      in_if.u_angle <= angle_q[0].u;
      in_if.v_angle <= angle_q[0].v;
      drive_gap     <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  // accepted word -> prediction
  always @(posedge clk_i) begin
    in_acc <= rst_ni && in_if.valid && in_if.ready;
    if (rst_ni && in_if.valid && in_if.ready) begin
      angle_t w;
      w = angle_q.pop_front();
      predict_surface(w);
    end
  end

  // sink stalls
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      sink_gap     <= 0;
    end else if (sink_gap > 0) begin
      out_if.ready <= 1'b0;
      sink_gap     <= sink_gap - 1;
    end else if (out_if.ready && out_if.valid) begin
      if ($urandom_range(0, 2) == 0) begin
        out_if.ready <= 1'b0;
        sink_gap     <= $urandom_range(0, 8);
      end
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      surf_vec_t e;
      if (vec_q.size() == 0) begin
        $error("unexpected vector word kind=%0d", out_if.vec_kind);
        errors++;
      end else begin
        e = vec_q.pop_front();
        if (out_if.vec_kind !== e.kind) begin
          $error("vec_kind expected %0d got %0d", e.kind, out_if.vec_kind);
          errors++;
        end
        if (out_if.vec_x !== e.x) begin
          $error("vec_x expected %0d got %0d", e.x, out_if.vec_x);
          errors++;
        end
        if (out_if.vec_y !== e.y) begin
          $error("vec_y expected %0d got %0d", e.y, out_if.vec_y);
          errors++;
        end
        if (out_if.vec_z !== e.z) begin
          $error("vec_z expected %0d got %0d", e.z, out_if.vec_z);
          errors++;
        end
        if (out_if.last_vec !== e.last) begin
          $error("last_vec expected %0d got %0d", e.last, out_if.last_vec);
          errors++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (angle_q.size() > 0 || vec_q.size() > 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_A_SCALE) coef_a = $signed(val);
    else if (idx == REG_B_TWIST) coef_b = $signed(val);
  endtask

  task automatic add_angle(logic [14:0] u, logic signed [14:0] v);
    angle_t w;
    w.u = u;
    w.v = v;
    angle_q.push_back(w);
  endtask

  task automatic add_random(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: add_angle(15'($urandom), 15'($urandom));
        1: add_angle(15'($urandom_range(25730, 32767)),
                     $urandom_range(0, 1) ? 15'sd12868 : -15'sd12868);
        default: add_angle(15'($urandom_range(0, 25736)),
                           15'($signed($urandom_range(0, 25736)) - 12868));
      endcase
    end
  endtask

  initial begin
    logic [15:0] a_set[5];
    logic [15:0] b_set[5];
    a_set = '{16'h1000, 16'h7fff, 16'h8000, 16'h0000, 16'hf000};
    b_set = '{16'h1000, 16'h8000, 16'h7fff, 16'hffff, 16'h0800};
    errors     = 0;
    hold_off   = 0;
    coef_a     = 4096;
    coef_b     = 4096;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    rst_ni     = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: corners, clamping, quadrant boundaries
    add_angle(15'd0, 15'sd0);
    add_angle(15'd25736, 15'sd12868);
    add_angle(15'd25736, -15'sd12868);
    add_angle(15'd25737, 15'sd12869);
    add_angle(15'h7fff, -15'sd12869);
    add_angle(15'h7fff, 15'sh3fff);
    add_angle(15'd0, 15'sh4000);
    add_angle(15'd12868, 15'sd6434);
    add_angle(15'd6434, -15'sd6434);
    add_angle(15'd6435, 15'sd6435);
    add_angle(15'd12869, -15'sd1);
    add_angle(15'd19302, 15'sd1);
    add_angle(15'd1, -15'sd6435);
    add_angle(15'h5555, 15'sh2aaa);
    add_angle(15'h2aaa, 15'sh5555);
    hold_off = 1;
    repeat (40) @(posedge clk_i);
    hold_off = 0;
    wait_drained();
    write_reg(2'd2, 16'h1234);
    write_reg(2'd3, 16'hffff);

    for (int p = 0; p < 5; p++) begin
      write_reg(REG_A_SCALE, a_set[p]);
      write_reg(REG_B_TWIST, b_set[p]);
      add_angle(15'd25736, 15'sd12868);
      add_angle(15'd0, -15'sd12868);
      add_random(70);
      wait_drained();
    end
    write_reg(REG_A_SCALE, 16'($urandom));
    write_reg(REG_B_TWIST, 16'($urandom));
    add_random(40);
    wait_drained();

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> files.f
rtl/tsse_pkg.sv
rtl/tsse_if.sv
rtl/tsse_cordic_cell.sv
rtl/tsse_vec_unit.sv
rtl/twisted_sphere_surface_eval_core.sv
sim/tb_twisted_sphere_surface_eval_core.sv
